/* sv/dbsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsm_pkg
// shared types, command codes and register indexes for the bank state machine
// ----------------------------------------------------------------------------
package dbsm_pkg;

  localparam int CmdW     = 5;
  localparam int NumCmd   = 19;
  localparam int RaaW     = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int RowFldW  = 16;
  localparam int TimeFldW = 40;

  // dram command codes
  localparam logic [CmdW-1:0] CMD_RD     = 5'd0;
  localparam logic [CmdW-1:0] CMD_RDA    = 5'd1;
  localparam logic [CmdW-1:0] CMD_WR     = 5'd2;
  localparam logic [CmdW-1:0] CMD_WRA    = 5'd3;
  localparam logic [CmdW-1:0] CMD_ACT    = 5'd4;
  localparam logic [CmdW-1:0] CMD_PRE    = 5'd5;
  localparam logic [CmdW-1:0] CMD_REFB   = 5'd6;
  localparam logic [CmdW-1:0] CMD_REFSB  = 5'd7;
  localparam logic [CmdW-1:0] CMD_REFAB  = 5'd8;
  localparam logic [CmdW-1:0] CMD_SRE    = 5'd9;
  localparam logic [CmdW-1:0] CMD_SRX    = 5'd10;
  localparam logic [CmdW-1:0] CMD_RFMSB  = 5'd11;
  localparam logic [CmdW-1:0] CMD_RFMAB  = 5'd12;
  localparam logic [CmdW-1:0] CMD_DRFMB  = 5'd13;
  localparam logic [CmdW-1:0] CMD_DRFMSB = 5'd14;
  localparam logic [CmdW-1:0] CMD_DRFMAB = 5'd15;
  localparam logic [CmdW-1:0] CMD_PREAB  = 5'd16;
  localparam logic [CmdW-1:0] CMD_PRESB  = 5'd17;
  localparam logic [CmdW-1:0] CMD_NONE   = 5'd18;

  // operations
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_ISSUE  = 2'd1;
  localparam logic [1:0] OP_TIMING = 2'd2;
  localparam logic [1:0] OP_MARK   = 2'd3;

  // bank states
  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_SREF   = 2'd2;

  // rfm kinds
  localparam logic [1:0] RFM_SB = 2'd1;
  localparam logic [1:0] RFM_AB = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_RFM_KIND    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_THR_SELECT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MGMT_THR    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INIT_THR    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REF_DEC     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RFM_DEC     = 3'd5;

  typedef struct packed {
    logic [1:0]      rfm_kind;
    logic            thr_select;
    logic [RaaW-1:0] mgmt_thr;
    logic [RaaW-1:0] init_thr;
    logic [RaaW-1:0] ref_dec;
    logic [RaaW-1:0] rfm_dec;
  } cfg_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [TimeFldW-1:0] earliest_time;
    logic [TimeFldW-1:0] now_time;
    logic [RowFldW-1:0]  row;
    logic [CmdW-1:0]     dram_cmd;
    logic [1:0]          command;
  } item_t;

  typedef struct packed {
    logic [RaaW-1:0]    raa_count;
    logic               in_drfm;
    logic               in_refresh;
    logic [RowFldW-1:0] open_row;
    logic [1:0]         bank_state;
    logic               error;
    logic [CmdW-1:0]    ready_cmd;
  } result_t;

endpackage

/* sv/dbsm_timing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsm_timing
// earliest-issue time per command, with readiness compare and raising update
// ----------------------------------------------------------------------------
module dbsm_timing #(
  parameter int TIME_BITS = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dbsm_pkg::CmdW-1:0]  rd_idx,
  input  logic [TIME_BITS-1:0]       now_time,
  output logic                       timely,
  input  logic                       wr_en,
  input  logic [dbsm_pkg::CmdW-1:0]  wr_idx,
  input  logic [TIME_BITS-1:0]       wr_time
);
  import dbsm_pkg::*;

  logic [TIME_BITS-1:0] earliest [NumCmd];
  logic [TIME_BITS-1:0] rd_time;
  logic                 wr_ok;

  always_comb begin
    rd_time = (rd_idx < CmdW'(NumCmd)) ? earliest[rd_idx] : '0;
    timely  = (now_time >= rd_time);
    wr_ok   = wr_en && (wr_idx < CmdW'(NumCmd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCmd; i++) begin
        earliest[i] <= '0;
      end
    end else if (wr_ok && (wr_time > earliest[wr_idx])) begin
      earliest[wr_idx] <= wr_time;
    end
  end

endmodule

/* sv/dbsm_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsm_bank
// bank state, activation counter and command mapping for one item per cycle while step is high
// ----------------------------------------------------------------------------
module dbsm_bank #(
  parameter int TIME_BITS = 40,
  parameter int ROW_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  dbsm_pkg::item_t   item,
  input  dbsm_pkg::cfg_t    cfg,
  output dbsm_pkg::result_t res
);
  import dbsm_pkg::*;

  logic [1:0]          mode, mode_next;
  logic [ROW_BITS-1:0] active_row, active_row_next;
  logic [RaaW-1:0]     raa, raa_next;
  logic                drfm_pending, drfm_pending_next;
  logic [CmdW-1:0]     last_issued, last_issued_next;

  logic [CmdW-1:0]      c;
  logic [ROW_BITS-1:0]  row_in;
  logic [TIME_BITS-1:0] now_in;
  logic [TIME_BITS-1:0] et_in;
  logic [RaaW-1:0]      thr;
  logic                 over;
  logic                 is_acc;
  logic [CmdW-1:0]      req;
  logic                 req_bad;
  logic                 timely;
  logic                 err;
  logic                 issue_bad;
  logic [CmdW-1:0]      ready;
  logic [RaaW-1:0]      raa_ref_sub, raa_rfm_sub;

  assign c      = item.dram_cmd;
  assign row_in = ROW_BITS'(item.row);
  assign now_in = TIME_BITS'(item.now_time);
  assign et_in  = TIME_BITS'(item.earliest_time);

  // query mapping
  always_comb begin
    thr     = cfg.thr_select ? cfg.mgmt_thr : cfg.init_thr;
    over    = (raa >= thr);
    is_acc  = (c <= CMD_WRA);
    req     = CMD_NONE;
    req_bad = 1'b0;
    case (mode)
      ST_CLOSED: begin
        if (is_acc) begin
          if (cfg.rfm_kind == RFM_SB && over) begin
            req = CMD_RFMSB;
          end else if (cfg.rfm_kind == RFM_AB && over) begin
            req = CMD_RFMAB;
          end else if (drfm_pending) begin
            req = CMD_NONE;
          end else begin
            req = CMD_ACT;
          end
        end else if (c inside {CMD_REFB, CMD_REFSB, CMD_REFAB, CMD_SRE, CMD_RFMSB,
                               CMD_RFMAB, CMD_DRFMB, CMD_DRFMSB, CMD_DRFMAB}) begin
          req = c;
        end else begin
          req_bad = 1'b1;
        end
      end
      ST_OPEN: begin
        if (is_acc) begin
          req = (row_in == active_row) ? c : CMD_PRE;
        end else if (c inside {CMD_REFB, CMD_DRFMB}) begin
          req = CMD_PRE;
        end else if (c inside {CMD_REFAB, CMD_RFMAB, CMD_DRFMAB, CMD_SRE}) begin
          req = CMD_PREAB;
        end else if (c inside {CMD_RFMSB, CMD_REFSB, CMD_DRFMSB}) begin
          req = CMD_PRESB;
        end else begin
          req_bad = 1'b1;
        end
      end
      default: begin
        if (is_acc) begin
          req = CMD_SRX;
        end else begin
          req_bad = 1'b1;
        end
      end
    endcase
  end

  dbsm_timing #(
    .TIME_BITS(TIME_BITS)
  ) u_timing (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (req),
    .now_time(now_in),
    .timely  (timely),
    .wr_en   (step && item.command == OP_TIMING),
    .wr_idx  (c),
    .wr_time (et_in)
  );

  // query result, issue and state update
  always_comb begin
    raa_ref_sub       = (raa > cfg.ref_dec) ? raa - cfg.ref_dec : '0;
    raa_rfm_sub       = (raa > cfg.rfm_dec) ? raa - cfg.rfm_dec : '0;
    mode_next         = mode;
    active_row_next   = active_row;
    raa_next          = raa;
    drfm_pending_next = drfm_pending;
    last_issued_next  = last_issued;
    issue_bad         = 1'b0;
    ready             = CMD_NONE;
    err               = 1'b0;
    case (item.command)
      OP_QUERY: begin
        err = req_bad;
        if (!req_bad && req != CMD_NONE && timely) begin
          ready = req;
        end
      end
      OP_ISSUE: begin
        case (mode)
          ST_OPEN: begin
            if (c inside {CMD_RDA, CMD_WRA, CMD_PRE, CMD_PREAB, CMD_PRESB}) begin
              mode_next       = ST_CLOSED;
              active_row_next = '0;
            end else if (!(c inside {CMD_RD, CMD_WR})) begin
              issue_bad = 1'b1;
            end
          end
          ST_CLOSED: begin
            if (c inside {CMD_REFB, CMD_REFSB, CMD_REFAB}) begin
              raa_next = raa_ref_sub;
            end else if (c inside {CMD_DRFMB, CMD_DRFMSB, CMD_DRFMAB}) begin
              drfm_pending_next = 1'b0;
              raa_next          = raa_rfm_sub;
            end else if (c inside {CMD_RFMSB, CMD_RFMAB}) begin
              raa_next = raa_rfm_sub;
            end else if (c == CMD_ACT) begin
              mode_next       = ST_OPEN;
              active_row_next = row_in;
              if (raa != '1) begin
                raa_next = raa + RaaW'(1);
              end
            end else if (c == CMD_SRE) begin
              mode_next = ST_SREF;
            end else if (!(c inside {CMD_PREAB, CMD_PRESB})) begin
              issue_bad = 1'b1;
            end
          end
          default: begin
            if (c == CMD_SRX) begin
              mode_next = ST_CLOSED;
            end else begin
              issue_bad = 1'b1;
            end
          end
        endcase
        if (!issue_bad) begin
          last_issued_next = c;
        end
        err = issue_bad;
      end
      OP_TIMING: begin
        err = (c >= CmdW'(NumCmd));
      end
      default: begin
        drfm_pending_next = 1'b1;
      end
    endcase

    res.ready_cmd  = ready;
    res.error      = err;
    res.bank_state = mode_next;
    res.open_row   = (mode_next == ST_OPEN) ? RowFldW'(active_row_next) : '0;
    res.in_refresh = (last_issued_next inside {CMD_REFB, CMD_REFSB, CMD_REFAB});
    res.in_drfm    = (last_issued_next inside {CMD_DRFMB, CMD_DRFMSB, CMD_DRFMAB});
    res.raa_count  = raa_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ST_CLOSED;
      active_row   <= '0;
      raa          <= '0;
      drfm_pending <= 1'b0;
      last_issued  <= CMD_NONE;
    end else if (step) begin
      mode         <= mode_next;
      active_row   <= active_row_next;
      raa          <= raa_next;
      drfm_pending <= drfm_pending_next;
      last_issued  <= last_issued_next;
    end
  end

  a_row_clear_unless_open: assert property (@(posedge clk) disable iff (rst)
    (mode != ST_OPEN) |-> (active_row == '0))
    else $error("active row kept while bank not open");

  a_mark_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (step && item.command == OP_MARK) |=> drfm_pending)
    else $error("drfm pending not set after mark");

  a_bad_issue_no_change: assert property (@(posedge clk) disable iff (rst)
    (step && item.command == OP_ISSUE && issue_bad)
      |=> ($stable(mode) && $stable(last_issued) && $stable(raa)))
    else $error("illegal issue changed bank state");

endmodule

/* sv/dram_bank_command_state_machine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dram_bank_command_state_machine_unit
// one dram bank: command mapping, issue tracking and earliest-issue timing
// ----------------------------------------------------------------------------
// Takes one transfer per clock while the result side keeps up, and returns
// one result per transfer: the item is held in an input register, the bank
// logic, the 19-entry earliest-issue table read and the time compare work on
// it in a single pass, and the result is held in an output register. The
// bank state is updated as the item moves to the output register, so a
// following item sees it in the next cycle. Holding tready low on the result
// side stalls the input side after the two registers fill.
module dram_bank_command_state_machine_unit #(
  parameter int TIME_BITS = 40,
  parameter int ROW_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // command, dram_cmd, row, now_time, earliest_time, zero fill
  input  logic [103:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ready_cmd, error, bank_state, open_row, in_refresh, in_drfm, raa_count, zero fill
  output logic [39:0]                   m_axis_tdata,
  input  logic                          cfg_wr_en,
  input  logic [dbsm_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [dbsm_pkg::CfgDataW-1:0] cfg_wdata
);
  import dbsm_pkg::*;

  localparam int ItemW = $bits(item_t);
  localparam int ResW  = $bits(result_t);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t res;
  result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RFM_KIND:   cfg.rfm_kind   <= cfg_wdata[1:0];
        REG_THR_SELECT: cfg.thr_select <= cfg_wdata[0];
        REG_MGMT_THR:   cfg.mgmt_thr   <= cfg_wdata[RaaW-1:0];
        REG_INIT_THR:   cfg.init_thr   <= cfg_wdata[RaaW-1:0];
        REG_REF_DEC:    cfg.ref_dec    <= cfg_wdata[RaaW-1:0];
        REG_RFM_DEC:    cfg.rfm_dec    <= cfg_wdata[RaaW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item <= item_t'(s_axis_tdata[ItemW-1:0]);
    end
  end

  dbsm_bank #(
    .TIME_BITS(TIME_BITS),
    .ROW_BITS (ROW_BITS)
  ) u_bank (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .item(s1_item),
    .cfg (cfg),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {(40 - ResW)'(0), res_q};

endmodule
